FILE: rtl/core/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter
// Register indexes, reset values, step counts and the code of the shared
// add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROCESS_NOISE      = 2'd0,
    REG_MEASUREMENT_NOISE  = 2'd1,
    REG_INITIAL_COVARIANCE = 2'd2
  } reg_index_t;

  // Reset values, unsigned Q8.24.
  localparam logic [31:0] PROCESS_NOISE_RESET     = 32'd16777;
  localparam logic [31:0] MEASUREMENT_NOISE_RESET = 32'd9110028;
  localparam logic [31:0] COVARIANCE_RESET        = 32'd335544;

  // One in the Q1.32 gain format, held in 33 bits.
  localparam logic [32:0] GAIN_ONE = 33'h1_0000_0000;

  // Sequencer step counter and the last step of each loop.
  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd31;
  localparam logic [CNT_W-1:0] MUL_LAST = 6'd32;

  // Operation of the shared add/subtract unit.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

`default_nettype wire

FILE: rtl/core/skf_alu.sv
// ----------------------------------------------------------------------------
// skf_alu: shared add/subtract unit
// Unsigned add or subtract with carry out; on a subtract the carry is set
// when the first operand is not below the second.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_alu #(
  parameter int unsigned WIDTH = 34
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire skf_pkg::alu_op_t op,
  output logic      [WIDTH:0]   y
);

  logic [WIDTH-1:0] b_term;
  logic             carry_in;

  // A subtract adds the inverted operand plus one.
  always_comb begin
    carry_in = (op == skf_pkg::ALU_SUB);
    b_term   = carry_in ? ~b : b;
    y        = (WIDTH+1)'(a) + (WIDTH+1)'(b_term) + (WIDTH+1)'(carry_in);
  end

endmodule

`default_nettype wire

FILE: rtl/core/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional Kalman filter
// Smooths a stream of signed Q16.16 samples. Covariance prediction, gain
// division, estimate update and covariance update all run through one shared
// add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel      | Direction | Handshake                           | Payload
//  -------------+-----------+-------------------------------------+-------------
//  measurement  | in        | measurement_valid/measurement_stall | measurement
//  estimate     | out       | estimate_valid/estimate_stall       | estimate
//  config       | in        | cfg_write (no wait)                 | cfg_index, cfg_data
//
//  Between acceptance and the next possible acceptance a request passes
//  through 5 set-up steps, a 32-step restoring division for the gain,
//  two 33-step shift-add multiplies and single steps to arm the multiplies,
//  update the estimate, store the result and return to idle, all on the one
//  shared adder.
//  Reset (synchronous, active high) clears the estimate, loads the covariance
//  with its reset value and returns the noise registers to theirs.
//  measurement_stall is high from acceptance until the result is loaded.
//  A stalled result holds the block in its last step until the output
//  register is free; the next request can be accepted while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // measurement channel
  input  wire logic                                measurement_valid,
  output logic                                     measurement_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      measurement,
  // estimate channel
  output logic                                     estimate_valid,
  input  wire logic                                estimate_stall,
  output logic signed [SAMPLE_WIDTH-1:0]           estimate,
  // configuration port
  input  wire logic                                cfg_write,
  input  wire logic [skf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [skf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned MAG_W = SW + 1;
  localparam int unsigned MUL_W = (MAG_W > 32) ? MAG_W : 32;
  localparam int unsigned ACC_W = MUL_W + 1;
  localparam int unsigned ADD_W = (ACC_W > 34) ? ACC_W : 34;

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_PRED, S_DEN, S_ERR, S_ABS, S_DIV0, S_DIV,
    S_MSET, S_MULG, S_EST, S_CSET, S_MULC, S_DONE
  } state_t;

  state_t state;

  // Configuration and filter state.
  logic [31:0]          process_noise;
  logic [31:0]          measurement_noise;
  logic [31:0]          covariance;
  logic signed [SW-1:0] estimate_reg;

  // Working registers of one request.
  logic signed [SW-1:0]         meas_reg;
  logic [31:0]                  p_reg;
  logic [32:0]                  den_reg;
  logic [33:0]                  rem;
  logic [32:0]                  gain;
  logic [32:0]                  mulb;
  logic [MAG_W-1:0]             mag;
  logic                         neg;
  logic [ACC_W-1:0]             acc;
  logic [skf_pkg::CNT_W-1:0]    cnt;

  // Shared unit operands.
  logic [ADD_W-1:0]  alu_a;
  logic [ADD_W-1:0]  alu_b;
  skf_pkg::alu_op_t  alu_op;
  logic [ADD_W:0]    alu_y;
  logic              alu_carry;

  logic [33:0]       rem_shift;
  logic [MUL_W-1:0]  mult_src;
  logic [ACC_W-1:0]  acc_sum;
  logic [SW+1:0]     est_sum;
  logic signed [SW-1:0] est_clamped;
  logic              out_free;

  skf_alu #(.WIDTH(ADD_W)) u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .y  (alu_y)
  );

  assign alu_carry         = alu_y[ADD_W];
  assign rem_shift         = {rem[32:0], 1'b0};
  assign mult_src          = (state == S_MULC) ? MUL_W'(p_reg) : MUL_W'(mag);
  assign acc_sum           = alu_y[ACC_W-1:0];
  assign est_sum           = alu_y[SW+1:0];
  assign out_free          = !estimate_valid || !estimate_stall;
  assign measurement_stall = (state != S_IDLE);

  // Clamp the updated estimate to the sample range.
  always_comb begin
    if ((est_sum[SW+1] == est_sum[SW]) && (est_sum[SW] == est_sum[SW-1])) begin
      est_clamped = $signed(est_sum[SW-1:0]);
    end else if (!est_sum[SW+1]) begin
      est_clamped = SMAX;
    end else begin
      est_clamped = SMIN;
    end
  end

  // Operand selection for the shared unit, one operation per step.
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = skf_pkg::ALU_ADD;
    unique case (state)
      S_PRED: begin
        alu_a = ADD_W'(covariance);
        alu_b = ADD_W'(process_noise);
      end
      S_DEN: begin
        alu_a = ADD_W'(p_reg);
        alu_b = ADD_W'(measurement_noise);
      end
      S_ERR: begin
        alu_a  = ADD_W'(meas_reg);
        alu_b  = ADD_W'(estimate_reg);
        alu_op = skf_pkg::ALU_SUB;
      end
      S_ABS: begin
        alu_b  = ADD_W'($signed(mag));
        alu_op = skf_pkg::ALU_SUB;
      end
      S_DIV0: begin
        alu_a  = ADD_W'(p_reg);
        alu_b  = ADD_W'(den_reg);
        alu_op = skf_pkg::ALU_SUB;
      end
      S_DIV: begin
        alu_a  = ADD_W'(rem_shift);
        alu_b  = ADD_W'(den_reg);
        alu_op = skf_pkg::ALU_SUB;
      end
      S_MULG, S_MULC: begin
        alu_a = ADD_W'(acc);
        alu_b = mulb[0] ? ADD_W'(mult_src) : '0;
      end
      S_EST: begin
        alu_a  = ADD_W'(estimate_reg);
        alu_b  = ADD_W'(acc);
        alu_op = neg ? skf_pkg::ALU_SUB : skf_pkg::ALU_ADD;
      end
      S_CSET: begin
        alu_a  = ADD_W'(skf_pkg::GAIN_ONE);
        alu_b  = ADD_W'(gain);
        alu_op = skf_pkg::ALU_SUB;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes. The initial covariance only matters at a reset,
  // which also returns it to its reset value, so nothing is stored for it.
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= skf_pkg::PROCESS_NOISE_RESET;
      measurement_noise <= skf_pkg::MEASUREMENT_NOISE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        skf_pkg::REG_PROCESS_NOISE:      process_noise     <= cfg_data;
        skf_pkg::REG_MEASUREMENT_NOISE:  measurement_noise <= cfg_data;
        skf_pkg::REG_INITIAL_COVARIANCE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer with the filter state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      estimate_reg   <= '0;
      covariance     <= skf_pkg::COVARIANCE_RESET;
      estimate_valid <= 1'b0;
    end else begin
      // Load a finished result, or retire the one taken by the receiver.
      if ((state == S_DONE) && out_free) begin
        estimate       <= estimate_reg;
        estimate_valid <= 1'b1;
      end else if (estimate_valid && !estimate_stall) begin
        estimate_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (measurement_valid) begin
            meas_reg <= measurement;
            state    <= S_PRED;
          end
        end
        // Predicted covariance, saturated at the top of the range.
        S_PRED: begin
          p_reg <= alu_y[32] ? '1 : alu_y[31:0];
          state <= S_DEN;
        end
        S_DEN: begin
          den_reg <= alu_y[32:0];
          state   <= S_ERR;
        end
        // Innovation, kept as sign and magnitude.
        S_ERR: begin
          mag   <= alu_y[MAG_W-1:0];
          neg   <= alu_y[MAG_W-1];
          state <= S_ABS;
        end
        S_ABS: begin
          if (neg) begin
            mag <= alu_y[MAG_W-1:0];
          end
          state <= S_DIV0;
        end
        // Integer bit of the gain; it is set only when the noise is zero.
        S_DIV0: begin
          gain  <= 33'(alu_carry);
          rem   <= alu_carry ? alu_y[33:0] : 34'(p_reg);
          cnt   <= '0;
          state <= S_DIV;
        end
        // Restoring division, one fraction bit of the gain per step.
        S_DIV: begin
          gain <= {gain[31:0], alu_carry};
          rem  <= alu_carry ? alu_y[33:0] : rem_shift;
          cnt  <= cnt + 1'b1;
          if (cnt == skf_pkg::DIV_LAST) begin
            state <= S_MSET;
          end
        end
        // A zero denominator gives a zero gain.
        S_MSET: begin
          if (den_reg == '0) begin
            gain <= '0;
            mulb <= '0;
          end else begin
            mulb <= gain;
          end
          acc   <= '0;
          cnt   <= '0;
          state <= S_MULG;
        end
        // Shift-add multiply, low multiplier bit first; the last step adds the
        // integer bit without a shift.
        S_MULG, S_MULC: begin
          mulb <= {1'b0, mulb[32:1]};
          cnt  <= cnt + 1'b1;
          if (cnt == skf_pkg::MUL_LAST) begin
            acc   <= acc_sum;
            state <= (state == S_MULG) ? S_EST : S_DONE;
          end else begin
            acc <= acc_sum >> 1;
          end
        end
        S_EST: begin
          estimate_reg <= est_clamped;
          state        <= S_CSET;
        end
        S_CSET: begin
          mulb  <= alu_y[32:0];
          acc   <= '0;
          cnt   <= '0;
          state <= S_MULC;
        end
        // New covariance, then back to idle once the output register is free.
        S_DONE: begin
          covariance <= acc[31:0];
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/skf_checker.sv
// ----------------------------------------------------------------------------
// skf_checker: port checks of the scalar Kalman filter
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_checker #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            measurement_valid,
  input wire logic                            measurement_stall,
  input wire logic [SAMPLE_WIDTH-1:0]         measurement,
  input wire logic                            estimate_valid,
  input wire logic                            estimate_stall,
  input wire logic [SAMPLE_WIDTH-1:0]         estimate
);

  logic in_take;

  assign in_take = measurement_valid && !measurement_stall;

  // An accepted request keeps the input stalled as its work begins.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> measurement_stall ##1 measurement_stall)
    else $error("input not stalled after an accepted request");

  // A stalled request holds its sample.
  a_request_holds: assert property (@(posedge clk) disable iff (rst)
    (measurement_valid && measurement_stall) |=>
      (measurement_valid && $stable(measurement)))
    else $error("stalled request changed");

  // A new result only appears while a request is in progress.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(estimate_valid) |-> $past(measurement_stall))
    else $error("result appeared without a request in progress");

  // No result is shown straight after reset.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !estimate_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (estimate_valid && estimate_stall) |=> (estimate_valid && $stable(estimate)))
    else $error("stalled result changed");

endmodule

bind scalar_kalman_filter skf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_skf_checker (
  .clk               (clk),
  .rst               (rst),
  .measurement_valid (measurement_valid),
  .measurement_stall (measurement_stall),
  .measurement       (measurement),
  .estimate_valid    (estimate_valid),
  .estimate_stall    (estimate_stall),
  .estimate          (estimate)
);

`default_nettype wire
